// ===== rtl/lrac_pkg.sv =====
// ----------------------------------------------------------------------------
// lrac_pkg
// Shared types and constants for the layered rgba alpha compositor.
// ----------------------------------------------------------------------------
package lrac_pkg;

    // channel layout of a packed pixel
    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int COLOR_CHANS = 3;
    localparam int DIV_STEPS  = 8;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // class of a queued layer word, decided at the front
    typedef enum logic [1:0] {
        OP_LOAD,    // topmost layer, loads the accumulator
        OP_SKIP,    // lower layer with zero alpha, no effect
        OP_MERGE    // lower layer that may show through
    } t_op;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        t_op              op;
        logic             last;
    } t_layer_word;

    // request to and response from the blend unit
    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_blend_req;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] pixel;
    } t_blend_rsp;

    typedef enum logic [1:0] {
        K_IDLE,
        K_BLEND,
        K_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_NUM,
        B_DIV
    } t_blend_state;

endpackage

// ===== rtl/lrac_front.sv =====
// ----------------------------------------------------------------------------
// lrac_front
// Accepts layer words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lrac_front #(
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [31:0]              i_layer_pixel,
    input  logic                     i_first_layer,
    input  logic                     i_last_layer,
    output logic                     o_head_valid,
    output lrac_pkg::t_layer_word    o_head,
    input  logic                     i_pop
);
    import lrac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_layer_word        r_queue [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_push;
    logic               w_pop;
    t_layer_word        w_word;

    // classify the incoming word
    always_comb begin
        w_word.pixel = i_layer_pixel;
        w_word.last  = i_last_layer;
        if (i_first_layer) begin
            w_word.op = OP_LOAD;
        end else if (i_layer_pixel[31:24] == ALPHA_CLEAR) begin
            w_word.op = OP_SKIP;
        end else begin
            w_word.op = OP_MERGE;
        end
    end

    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = i_pop && o_head_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_word;
        end
    end

endmodule

// ===== rtl/lrac_blend.sv =====
// ----------------------------------------------------------------------------
// lrac_blend
// Over operator for two non-trivial pixels: products, numerators, then an
// eight-step restoring division of the three colour lanes by one divisor.
// ----------------------------------------------------------------------------
module lrac_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrac_pkg::t_blend_req   i_req,
    output lrac_pkg::t_blend_rsp   o_rsp
);
    import lrac_pkg::*;

    t_blend_state       r_state;
    t_blend_state       n_state;
    logic [31:0]        r_upper;
    logic [31:0]        r_lower;
    logic [15:0]        r_den;
    logic [8:0]         r_inv;
    logic [15:0]        r_t1  [COLOR_CHANS];
    logic [15:0]        r_t0  [COLOR_CHANS];
    logic [15:0]        r_rem [COLOR_CHANS];
    logic [7:0]         r_quo [COLOR_CHANS];
    logic [2:0]         r_step;
    logic               r_done;
    logic               n_done;

    logic [7:0]         w_a1;
    logic [7:0]         w_a0;
    logic [8:0]         w_asum;
    logic [17:0]        w_den_full;
    logic [15:0]        w_t1   [COLOR_CHANS];
    logic [15:0]        w_t0   [COLOR_CHANS];
    logic [24:0]        w_num  [COLOR_CHANS];
    logic [16:0]        w_trial[COLOR_CHANS];
    logic [16:0]        w_diff [COLOR_CHANS];
    logic               w_ge   [COLOR_CHANS];
    logic               w_last_step;

    assign w_a1        = r_upper[31:24];
    assign w_a0        = r_lower[31:24];
    assign w_asum      = {1'b0, w_a1} + {1'b0, w_a0};
    assign w_den_full  = {1'b0, w_asum, 8'h00} - {2'b00, {8'h00, w_a1} * {8'h00, w_a0}};
    assign w_last_step = (r_step == 3'(DIV_STEPS - 1));

    // per-lane products, numerators and division step
    always_comb begin
        for (int k = 0; k < COLOR_CHANS; k++) begin
            w_t1[k]    = {8'h00, r_upper[k*CHAN_W +: CHAN_W]} * {8'h00, w_a1};
            w_t0[k]    = {8'h00, r_lower[k*CHAN_W +: CHAN_W]} * {8'h00, w_a0};
            w_num[k]   = {1'b0, r_t1[k], 8'h00} + ({9'h000, r_t0[k]} * {16'h0000, r_inv});
            w_trial[k] = {r_rem[k], r_quo[k][7]};
            w_ge[k]    = (w_trial[k] >= {1'b0, r_den});
            w_diff[k]  = w_trial[k] - {1'b0, r_den};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_req.start) begin
                    n_state = B_MUL;
                end
            end
            B_MUL:  n_state = B_NUM;
            B_NUM:  n_state = B_DIV;
            B_DIV: begin
                if (w_last_step) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_done = (r_state == B_DIV) && w_last_step;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.pixel = {r_den[15:8], r_quo[2], r_quo[1], r_quo[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_req.start) begin
                    r_upper <= i_req.upper;
                    r_lower <= i_req.lower;
                end
            end
            B_MUL: begin
                r_den <= w_den_full[15:0];
                r_inv <= 9'h100 - {1'b0, w_a1};
                for (int k = 0; k < COLOR_CHANS; k++) begin
                    r_t1[k] <= w_t1[k];
                    r_t0[k] <= w_t0[k];
                end
            end
            B_NUM: begin
                r_step <= '0;
                for (int k = 0; k < COLOR_CHANS; k++) begin
                    r_rem[k] <= w_num[k][23:8];
                    r_quo[k] <= w_num[k][7:0];
                end
            end
            B_DIV: begin
                r_step <= r_step + 1'b1;
                for (int k = 0; k < COLOR_CHANS; k++) begin
                    r_rem[k] <= w_ge[k] ? w_diff[k][15:0] : w_trial[k][15:0];
                    r_quo[k] <= {r_quo[k][6:0], w_ge[k]};
                end
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

endmodule

// ===== rtl/lrac_back.sv =====
// ----------------------------------------------------------------------------
// lrac_back
// Holds the accumulated pixel, applies queued layer words and drives the
// output word register.
// ----------------------------------------------------------------------------
module lrac_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_head_valid,
    input  lrac_pkg::t_layer_word  i_head,
    output logic                   o_pop,
    output lrac_pkg::t_blend_req   o_req,
    input  lrac_pkg::t_blend_rsp   i_rsp,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_blended_pixel
);
    import lrac_pkg::*;

    t_back_state    r_state;
    t_back_state    n_state;
    logic [31:0]    r_acc;
    logic [31:0]    n_acc;
    logic           r_last;
    logic           r_out_valid;
    logic           n_out_valid;
    logic [31:0]    r_out;
    logic [31:0]    n_out;

    logic [7:0]     w_acc_alpha;
    logic           w_out_free;
    logic           w_need_blend;
    logic           w_imm_go;

    assign w_acc_alpha  = r_acc[31:24];
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_need_blend = i_head_valid && (i_head.op == OP_MERGE)
                          && (w_acc_alpha != ALPHA_OPAQUE) && (w_acc_alpha != ALPHA_CLEAR);
    assign w_imm_go     = i_head_valid && !w_need_blend && (!i_head.last || w_out_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            K_IDLE: begin
                if (w_need_blend) begin
                    n_state = K_BLEND;
                end
            end
            K_BLEND: begin
                if (i_rsp.done) begin
                    n_state = r_last ? K_EMIT : K_IDLE;
                end
            end
            K_EMIT: begin
                if (w_out_free) begin
                    n_state = K_IDLE;
                end
            end
            default: n_state = K_IDLE;
        endcase
    end

    // outputs and accumulator update
    always_comb begin
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        o_req.start = 1'b0;
        o_req.upper = r_acc;
        o_req.lower = i_head.pixel;
        unique case (r_state)
            K_IDLE: begin
                if (w_need_blend) begin
                    o_pop       = 1'b1;
                    o_req.start = 1'b1;
                end else if (w_imm_go) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_LOAD:  n_acc = i_head.pixel;
                        OP_MERGE: begin
                            // transparent accumulator takes the lower pixel
                            if (w_acc_alpha == ALPHA_CLEAR) begin
                                n_acc = i_head.pixel;
                            end
                        end
                        default:  n_acc = r_acc;
                    endcase
                    if (i_head.last) begin
                        n_out       = n_acc;
                        n_out_valid = 1'b1;
                    end
                end
            end
            K_BLEND: begin
                if (i_rsp.done) begin
                    n_acc = i_rsp.pixel;
                end
            end
            K_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                end
            end
            default: n_acc = r_acc;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_blended_pixel = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= K_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_need_blend && (r_state == K_IDLE)) begin
            r_last <= i_head.last;
        end
    end

endmodule

// ===== rtl/layered_rgba_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// layered_rgba_alpha_compositor
// Composites layer words topmost first into one rgba pixel per last layer.
// Load, skip, copy and opaque layers go from the queue straight to the
//   accumulator and output register; a blended layer passes the blend unit.
// Throughput: one word per cycle for non-blending layers while the output is
//   not stalled; a blended layer holds the back end until the divider ends.
// Reset clears the queue, the accumulator (transparent black) and output valid.
// ----------------------------------------------------------------------------
module layered_rgba_alpha_compositor #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_layer_pixel,
    input  logic        i_first_layer,
    input  logic        i_last_layer,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_blended_pixel
);
    import lrac_pkg::*;

    logic           w_head_valid;
    t_layer_word    w_head;
    logic           w_pop;
    t_blend_req     w_req;
    t_blend_rsp     w_rsp;

    // accept and classify
    lrac_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_layer_pixel (i_layer_pixel),
        .i_first_layer (i_first_layer),
        .i_last_layer  (i_last_layer),
        .o_head_valid  (w_head_valid),
        .o_head        (w_head),
        .i_pop         (w_pop)
    );

    // over operator unit
    lrac_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // accumulator and output word
    lrac_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_req           (w_req),
        .i_rsp           (w_rsp),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_blended_pixel (o_blended_pixel)
    );

endmodule
